// ----- hdl/wav_header_parse_and_data_gate_macros.svh -----
// Assertion macros used by the port-level checker of the WAV header parser.
// No dependencies; the including scope must provide clk and arst_n.
`ifndef WAV_HEADER_PARSE_AND_DATA_GATE_MACROS_SVH
`define WAV_HEADER_PARSE_AND_DATA_GATE_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define WAVHDR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define WAVHDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/wavhdr_pkg.sv -----
// Types and constants for the WAV header parser and data gate.
// No dependencies.
`timescale 1ns / 1ps

package wavhdr_pkg;

	typedef enum logic [12:0] {
		PH_RIFF       = 13'h0001,
		PH_RSIZE      = 13'h0002,
		PH_WAVE       = 13'h0004,
		PH_CID        = 13'h0008,
		PH_CSIZE      = 13'h0010,
		PH_FMT        = 13'h0020,
		PH_SKIP       = 13'h0040,
		PH_DATA       = 13'h0080,
		PH_PAST       = 13'h0100,
		PH_E_RIFF     = 13'h0200,
		PH_E_FMT      = 13'h0400,
		PH_E_MISMATCH = 13'h0800,
		PH_E_TRUNC    = 13'h1000
	} phase_t;

	typedef logic [2:0] status_t;
	typedef logic [1:0] cfg_index_t;

	localparam status_t ST_HEADER   = 3'd0;
	localparam status_t ST_DATA     = 3'd1;
	localparam status_t ST_PAST     = 3'd2;
	localparam status_t ST_BAD_RIFF = 3'd3;
	localparam status_t ST_BAD_FMT  = 3'd4;
	localparam status_t ST_MISMATCH = 3'd5;
	localparam status_t ST_TRUNC    = 3'd6;

	localparam cfg_index_t REG_RATE     = 2'd0;
	localparam cfg_index_t REG_CHANNELS = 2'd1;
	localparam cfg_index_t REG_BITS     = 2'd2;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [15:0] FMT_PCM        = 16'h0001;
	localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
	localparam logic [4:0]  TAG_BYTES      = 5'd4;

	localparam logic [31:0] RST_RATE     = 32'd16000;
	localparam logic [15:0] RST_CHANNELS = 16'd1;
	localparam logic [15:0] RST_BITS     = 16'd16;

endpackage

// ----- hdl/wav_header_parse_and_data_gate.sv -----
// WAV (RIFF/PCM) header parser and data gate, top level.
// Depends on wavhdr_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one file byte per transfer with
//   first_byte/final_byte marks. A first byte restarts parsing.
//   Output channel (out_valid/out_ready) returns exactly one result per input
//   transfer: audio_byte, status and data_end.
//   Config port: cfg_wr_en/cfg_index/cfg_data write expected rate (0),
//   channels (1) and bits (2); write only while the block is idle.
// Timing:
//   Results are valid in the cycle after the input transfer. Throughput is
//   one byte per cycle unless a result stalls; the parse state update is a
//   single compare/counter step per byte between state and result registers.
// Reset:
//   arst_n clears the parser to the RIFF tag phase, drops out_valid and loads
//   the config registers with 16000 Hz, 1 channel, 16 bits.
// Stall:
//   A held result keeps out_valid high; in_ready stays high while the result
//   register is empty or being taken in the same cycle, low otherwise.
`timescale 1ns / 1ps

module wav_header_parse_and_data_gate (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             file_byte,
	input  logic                   first_byte,
	input  logic                   final_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             audio_byte,
	output wavhdr_pkg::status_t    status,
	output logic                   data_end,
	input  logic                   cfg_wr_en,
	input  wavhdr_pkg::cfg_index_t cfg_index,
	input  logic [31:0]            cfg_data
);
	import wavhdr_pkg::*;

	logic [31:0] exp_rate_q;
	logic [15:0] exp_ch_q;
	logic [15:0] exp_bits_q;

	phase_t      phase_q;
	logic [4:0]  fc_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic [32:0] skip_q;
	logic [15:0] ch_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic [31:0] left_q;

	logic        out_valid_q;
	logic [7:0]  audio_q;
	status_t     status_q;
	logic        end_q;

	phase_t      cur_phase, nxt_phase;
	logic [4:0]  cur_fc, nxt_fc, fc_inc;
	logic [31:0] cur_tag, nxt_tag, tag_sh;
	logic [31:0] cur_len, nxt_len, len_sh;
	logic [32:0] cur_skip, nxt_skip;
	logic [15:0] cur_ch, nxt_ch;
	logic [31:0] cur_rate, nxt_rate;
	logic [15:0] cur_bits, nxt_bits;
	logic [31:0] cur_left, nxt_left, left_dec;
	logic [31:0] body_rest;
	logic [32:0] body_skip;
	logic        body_odd;
	logic        was_data;
	logic        end_d;
	status_t     status_d;
	logic        accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_rate_q <= RST_RATE;
			exp_ch_q   <= RST_CHANNELS;
			exp_bits_q <= RST_BITS;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RATE:     exp_rate_q <= cfg_data;
				REG_CHANNELS: exp_ch_q   <= cfg_data[15:0];
				REG_BITS:     exp_bits_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// first byte restarts parsing before the byte is used
	always_comb begin
		if (first_byte) begin
			cur_phase = PH_RIFF;
			cur_fc    = '0;
			cur_tag   = '0;
			cur_len   = '0;
			cur_skip  = '0;
			cur_ch    = '0;
			cur_rate  = '0;
			cur_bits  = '0;
			cur_left  = '0;
		end else begin
			cur_phase = phase_q;
			cur_fc    = fc_q;
			cur_tag   = tag_q;
			cur_len   = len_q;
			cur_skip  = skip_q;
			cur_ch    = ch_q;
			cur_rate  = rate_q;
			cur_bits  = bits_q;
			cur_left  = left_q;
		end
	end

	assign fc_inc   = cur_fc + 5'd1;
	assign tag_sh   = {cur_tag[23:0], file_byte};
	assign len_sh   = {file_byte, cur_len[31:8]};
	assign left_dec = cur_left - 32'd1;

	// padded remainder of a chunk body
	always_comb begin
		if (cur_phase == PH_FMT) begin
			body_rest = cur_len - FMT_BODY_BYTES;
			body_odd  = cur_len[0];
		end else begin
			body_rest = len_sh;
			body_odd  = len_sh[0];
		end
		body_skip = {1'b0, body_rest} + {32'd0, body_odd};
	end

	always_comb begin
		nxt_phase = cur_phase;
		nxt_fc    = cur_fc;
		nxt_tag   = cur_tag;
		nxt_len   = cur_len;
		nxt_skip  = cur_skip;
		nxt_ch    = cur_ch;
		nxt_rate  = cur_rate;
		nxt_bits  = cur_bits;
		nxt_left  = cur_left;
		was_data  = 1'b0;
		end_d     = 1'b0;

		unique case (cur_phase) inside
			PH_RIFF, PH_WAVE, PH_CID: begin
				nxt_tag = tag_sh;
				nxt_fc  = fc_inc;
				if (fc_inc >= TAG_BYTES) begin
					nxt_fc = '0;
					if (cur_phase == PH_RIFF) begin
						nxt_phase = (tag_sh == TAG_RIFF) ? PH_RSIZE : PH_E_RIFF;
					end else if (cur_phase == PH_WAVE) begin
						nxt_phase = (tag_sh == TAG_WAVE) ? PH_CID : PH_E_RIFF;
					end else begin
						nxt_len   = '0;
						nxt_phase = PH_CSIZE;
					end
				end
			end
			PH_RSIZE: begin
				nxt_fc = fc_inc;
				if (fc_inc >= TAG_BYTES) begin
					nxt_fc    = '0;
					nxt_phase = PH_WAVE;
				end
			end
			PH_CSIZE: begin
				nxt_len = len_sh;
				nxt_fc  = fc_inc;
				if (fc_inc >= TAG_BYTES) begin
					nxt_fc = '0;
					if (cur_tag == TAG_FMT) begin
						nxt_phase = (len_sh < FMT_BODY_BYTES) ? PH_E_FMT : PH_FMT;
					end else if (cur_tag == TAG_DATA) begin
						if (cur_ch == exp_ch_q && cur_bits == exp_bits_q &&
							cur_rate == exp_rate_q) begin
							nxt_left  = len_sh;
							nxt_phase = (len_sh != '0) ? PH_DATA : PH_PAST;
							if (final_byte) begin
								end_d     = 1'b1;
								nxt_phase = PH_PAST;
							end
						end else begin
							nxt_phase = PH_E_MISMATCH;
						end
					end else begin
						nxt_skip  = body_skip;
						nxt_phase = (body_skip != '0) ? PH_SKIP : PH_CID;
					end
				end
			end
			PH_FMT: begin
				nxt_fc = fc_inc;
				case (cur_fc[3:0])
					4'd0:  nxt_tag = {24'd0, file_byte};
					4'd1:  nxt_tag = cur_tag | {16'd0, file_byte, 8'd0};
					4'd2:  nxt_ch = {8'd0, file_byte};
					4'd3:  nxt_ch = {file_byte, cur_ch[7:0]};
					4'd4:  nxt_rate[7:0]   = file_byte;
					4'd5:  nxt_rate[15:8]  = file_byte;
					4'd6:  nxt_rate[23:16] = file_byte;
					4'd7:  nxt_rate[31:24] = file_byte;
					4'd14: nxt_bits = {8'd0, file_byte};
					4'd15: nxt_bits = {file_byte, cur_bits[7:0]};
					default: ;
				endcase
				if (cur_fc[3:0] == 4'd1 && {file_byte, cur_tag[7:0]} != FMT_PCM) begin
					nxt_phase = PH_E_FMT;
					nxt_fc    = '0;
				end else if (fc_inc >= FMT_BODY_BYTES[4:0]) begin
					nxt_fc    = '0;
					nxt_skip  = body_skip;
					nxt_phase = (body_skip != '0) ? PH_SKIP : PH_CID;
				end
			end
			PH_SKIP: begin
				nxt_skip = cur_skip - 33'd1;
				if (cur_skip == 33'd1) begin
					nxt_phase = PH_CID;
				end
			end
			PH_DATA: begin
				was_data = 1'b1;
				nxt_left = left_dec;
				if (left_dec == '0 || final_byte) begin
					end_d     = 1'b1;
					nxt_phase = PH_PAST;
				end
			end
			default: ;
		endcase

		if (final_byte && (nxt_phase inside {PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID,
			PH_CSIZE, PH_FMT, PH_SKIP})) begin
			nxt_phase = PH_E_TRUNC;
		end

		if (was_data) begin
			status_d = ST_DATA;
		end else begin
			unique case (nxt_phase)
				PH_PAST:       status_d = ST_PAST;
				PH_E_RIFF:     status_d = ST_BAD_RIFF;
				PH_E_FMT:      status_d = ST_BAD_FMT;
				PH_E_MISMATCH: status_d = ST_MISMATCH;
				PH_E_TRUNC:    status_d = ST_TRUNC;
				default:       status_d = ST_HEADER;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			fc_q    <= '0;
			tag_q   <= '0;
			len_q   <= '0;
			skip_q  <= '0;
			ch_q    <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			left_q  <= '0;
		end else if (accept) begin
			phase_q <= nxt_phase;
			fc_q    <= nxt_fc;
			tag_q   <= nxt_tag;
			len_q   <= nxt_len;
			skip_q  <= nxt_skip;
			ch_q    <= nxt_ch;
			rate_q  <= nxt_rate;
			bits_q  <= nxt_bits;
			left_q  <= nxt_left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			audio_q  <= was_data ? file_byte : 8'd0;
			status_q <= status_d;
			end_q    <= end_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign audio_byte = audio_q;
	assign status     = status_q;
	assign data_end   = end_q;

endmodule

// ----- hdl/wavhdr_checker.sv -----
// Port-level checks for the WAV header parser and data gate, bound to the top.
// Depends on wavhdr_pkg and wav_header_parse_and_data_gate_macros.svh.
`timescale 1ns / 1ps
`include "wav_header_parse_and_data_gate_macros.svh"

module wavhdr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [7:0]          audio_byte,
	input wavhdr_pkg::status_t status,
	input logic                data_end
);
	import wavhdr_pkg::*;

	// held result must not change
	`WAVHDR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(audio_byte) && $stable(status) && $stable(data_end), "stalled result changed")

	// every input transfer gives a result in the cycle after the transfer
	`WAVHDR_ASSERT_NEXT(a_latency, in_valid && in_ready, out_valid, "no result after input transfer")

	// data end only flagged in or just past the data chunk
	`WAVHDR_ASSERT(a_end_status, !(out_valid && data_end) || status == ST_DATA || status == ST_PAST, "data_end with wrong status")

	// audio byte is zero unless data is being passed
	`WAVHDR_ASSERT(a_audio_gate, !(out_valid && status != ST_DATA) || audio_byte == 8'd0, "audio byte outside data")

endmodule

bind wav_header_parse_and_data_gate wavhdr_checker u_wavhdr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.audio_byte (audio_byte),
	.status     (status),
	.data_end   (data_end)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for wav_header_parse_and_data_gate: directed bytes, then random files.
// Depends on wavhdr_pkg and the RTL of the WAV header parser.
`timescale 1ns / 1ps

module tb;
	import wavhdr_pkg::*;

	localparam int CLK_PERIOD        = 10;
	localparam int RESET_CYCLES      = 11;
	localparam int NUM_DIRECTED      = 15;
	localparam int RANDOM_ITEMS      = 1500;
	localparam int FILES_PER_SETTING = 7;
	localparam int DRAIN_CYCLES      = 8;
	localparam int TIMEOUT_NS        = 10_000_000;

	typedef struct packed {
		logic [7:0] audio;
		status_t    st;
		logic       last;
	} gate_out_t;

	typedef struct {
		logic [7:0] byte_val;
		logic       is_first;
		logic       is_last;
		gate_out_t  res;
	} stim_row_t;

	typedef enum int {
		FK_CLEAN, FK_NO_FMT, FK_TWO_FMT, FK_NON_PCM, FK_SHORT_FMT, FK_MISMATCH,
		FK_EMPTY_DATA, FK_END_AT_HDR, FK_END_IN_DATA, FK_TRUNC_HDR, FK_BAD_TAG,
		FK_HUGE_CHUNK, FK_NOISE, FK_COUNT
	} file_kind_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] file_byte   = 8'h00;
	logic       first_byte  = 1'b0;
	logic       final_byte  = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] audio_byte;
	status_t    status;
	logic       data_end;
	logic       cfg_wr_en   = 1'b0;
	cfg_index_t cfg_index   = REG_RATE;
	logic [31:0] cfg_data   = 32'h0;

	// predictor copy of the parser state and registers
	phase_t      ph;
	logic [4:0]  fcnt;
	logic [31:0] tag_sr;
	logic [31:0] clen;
	logic [32:0] skip_cnt;
	logic [15:0] got_ch;
	logic [31:0] got_rate;
	logic [15:0] got_bits;
	logic [31:0] data_left;
	logic [31:0] want_rate;
	logic [15:0] want_ch;
	logic [15:0] want_bits;

	gate_out_t   pending_results [$];
	logic [7:0]  file_q [$];
	stim_row_t   directed_rows [NUM_DIRECTED];
	int          errors      = 0;
	int          items_sent  = 0;
	int          files_sent  = 0;
	int          cfg_rounds  = 0;
	int          stall_left  = 0;
	int          status_hits [8];
	bit          tx_steady   = 1'b0;
	bit          rx_steady   = 1'b0;

	wav_header_parse_and_data_gate u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.file_byte  (file_byte),
		.first_byte (first_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.audio_byte (audio_byte),
		.status     (status),
		.data_end   (data_end),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void restart_parse();
		ph        = PH_RIFF;
		fcnt      = '0;
		tag_sr    = '0;
		clen      = '0;
		skip_cnt  = '0;
		got_ch    = '0;
		got_rate  = '0;
		got_bits  = '0;
		data_left = '0;
	endfunction

	function automatic bit tag_step(logic [7:0] b);
		tag_sr = {tag_sr[23:0], b};
		fcnt = fcnt + 5'd1;
		if (fcnt < TAG_BYTES) return 1'b0;
		fcnt = '0;
		return 1'b1;
	endfunction

	// body done: skip whatever is left plus the pad byte
	function automatic void set_skip(logic [32:0] rest);
		skip_cnt = rest + 33'(clen[0]);
		ph = (skip_cnt != '0) ? PH_SKIP : PH_CID;
	endfunction

	function automatic gate_out_t parse_wav_byte(logic [7:0] b, logic is_first, logic is_last);
		gate_out_t r;
		logic      was_data;
		logic      fmt_bad;
		logic [3:0] idx;
		int        sh;
		r = '0;
		was_data = 1'b0;
		fmt_bad = 1'b0;
		if (is_first) restart_parse();
		case (ph)
			PH_RIFF: if (tag_step(b)) ph = (tag_sr == TAG_RIFF) ? PH_RSIZE : PH_E_RIFF;
			PH_RSIZE: begin
				fcnt = fcnt + 5'd1;
				if (fcnt >= TAG_BYTES) begin
					fcnt = '0;
					ph = PH_WAVE;
				end
			end
			PH_WAVE: if (tag_step(b)) ph = (tag_sr == TAG_WAVE) ? PH_CID : PH_E_RIFF;
			PH_CID: begin
				if (tag_step(b)) begin
					clen = '0;
					ph = PH_CSIZE;
				end
			end
			PH_CSIZE: begin
				clen = {b, clen[31:8]};
				fcnt = fcnt + 5'd1;
				if (fcnt >= TAG_BYTES) begin
					fcnt = '0;
					if (tag_sr == TAG_FMT) begin
						ph = (clen < FMT_BODY_BYTES) ? PH_E_FMT : PH_FMT;
					end else if (tag_sr == TAG_DATA) begin
						if (got_ch == want_ch && got_bits == want_bits && got_rate == want_rate) begin
							data_left = clen;
							ph = (data_left != '0) ? PH_DATA : PH_PAST;
							if (is_last) begin
								r.last = 1'b1;
								ph = PH_PAST;
							end
						end else begin
							ph = PH_E_MISMATCH;
						end
					end else begin
						set_skip({1'b0, clen});
					end
				end
			end
			PH_FMT: begin
				idx = fcnt[3:0];
				case (idx)
					4'd0: tag_sr = {24'h0, b};
					4'd1: begin
						tag_sr = tag_sr | (32'(b) << 8);
						if (tag_sr != 32'(FMT_PCM)) begin
							ph = PH_E_FMT;
							fcnt = '0;
							fmt_bad = 1'b1;
						end
					end
					4'd2: got_ch = {8'h00, b};
					4'd3: got_ch[15:8] = b;
					4'd4, 4'd5, 4'd6, 4'd7: begin
						sh = 8 * (int'(idx) - 4);
						got_rate[sh +: 8] = b;
					end
					4'd14: got_bits = {8'h00, b};
					4'd15: got_bits[15:8] = b;
					default: ;
				endcase
				if (!fmt_bad) begin
					fcnt = fcnt + 5'd1;
					if (fcnt >= FMT_BODY_BYTES) begin
						fcnt = '0;
						set_skip({1'b0, clen - FMT_BODY_BYTES});
					end
				end
			end
			PH_SKIP: begin
				skip_cnt = skip_cnt - 33'd1;
				if (skip_cnt == '0) ph = PH_CID;
			end
			PH_DATA: begin
				was_data = 1'b1;
				r.audio = b;
				data_left = data_left - 32'd1;
				if (data_left == '0 || is_last) begin
					r.last = 1'b1;
					ph = PH_PAST;
				end
			end
			default: ;
		endcase
		if (is_last && (ph inside {PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_FMT, PH_SKIP}))
			ph = PH_E_TRUNC;
		if (was_data) begin
			r.st = ST_DATA;
		end else begin
			case (ph)
				PH_PAST:       r.st = ST_PAST;
				PH_E_RIFF:     r.st = ST_BAD_RIFF;
				PH_E_FMT:      r.st = ST_BAD_FMT;
				PH_E_MISMATCH: r.st = ST_MISMATCH;
				PH_E_TRUNC:    r.st = ST_TRUNC;
				default:       r.st = ST_HEADER;
			endcase
		end
		return r;
	endfunction

	// result channel: random backpressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left <= idle_len() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		gate_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: status %0d", status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				status_hits[want.st]++;
				if (audio_byte !== want.audio) begin
					$error("audio_byte: expected %0d, got %0d", want.audio, audio_byte);
					errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
				if (data_end !== want.last) begin
					$error("data_end: expected %0d, got %0d", want.last, data_end);
					errors++;
				end
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last,
				 input bit use_typed, input gate_out_t typed_res);
		gate_out_t pred;
		int        gap;
		gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		file_byte <= b;
		first_byte <= is_first;
		final_byte <= is_last;
		do @(posedge clk); while (!in_ready);
		pred = parse_wav_byte(b, is_first, is_last);
		pending_results.push_back(use_typed ? typed_res : pred);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_cfg(input cfg_index_t idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_RATE:     want_rate = val;
			REG_CHANNELS: want_ch = val[15:0];
			default:      want_bits = val[15:0];
		endcase
		@(negedge clk);
	endtask

	task automatic new_setting();
		logic [31:0] rate;
		logic [15:0] ch;
		logic [15:0] bits;
		in_valid <= 1'b0;
		wait_drained();
		case (cfg_rounds)
			0: begin
				rate = '0;
				ch = '0;
				bits = '0;
			end
			1: begin
				rate = '1;
				ch = '1;
				bits = '1;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: rate = 32'd8000;
					1: rate = 32'd44100;
					2: rate = 32'd48000;
					3: rate = 32'd96000;
					default: rate = $urandom;
				endcase
				case ($urandom_range(0, 2))
					0: ch = 16'd1;
					1: ch = 16'd2;
					default: ch = 16'($urandom);
				endcase
				case ($urandom_range(0, 4))
					0: bits = 16'd8;
					1: bits = 16'd16;
					2: bits = 16'd24;
					3: bits = 16'd32;
					default: bits = 16'($urandom);
				endcase
			end
		endcase
		// junk in the upper half of the 16-bit registers must be dropped
		write_cfg(REG_RATE, rate);
		write_cfg(REG_CHANNELS, {16'($urandom), ch});
		write_cfg(REG_BITS, {16'($urandom), bits});
		cfg_wr_en <= 1'b0;
		cfg_rounds++;
	endtask

	task automatic put_tag(input logic [31:0] t);
		file_q.push_back(t[31:24]);
		file_q.push_back(t[23:16]);
		file_q.push_back(t[15:8]);
		file_q.push_back(t[7:0]);
	endtask

	task automatic put_le32(input logic [31:0] v);
		file_q.push_back(v[7:0]);
		file_q.push_back(v[15:8]);
		file_q.push_back(v[23:16]);
		file_q.push_back(v[31:24]);
	endtask

	task automatic put_le16(input logic [15:0] v);
		file_q.push_back(v[7:0]);
		file_q.push_back(v[15:8]);
	endtask

	task automatic put_rand(input int n);
		repeat (n) file_q.push_back(8'($urandom));
	endtask

	task automatic put_other_chunk(input logic [31:0] size, input int body_len);
		logic [31:0] id;
		id = $urandom;
		if (id == TAG_FMT || id == TAG_DATA) id = id ^ 32'h1;
		put_tag(id);
		put_le32(size);
		put_rand(body_len);
	endtask

	task automatic put_fmt(input logic [31:0] size, input logic [15:0] ftag, input logic [15:0] ch,
			       input logic [31:0] rate, input logic [15:0] bits);
		put_tag(TAG_FMT);
		put_le32(size);
		if (size >= FMT_BODY_BYTES) begin
			put_le16(ftag);
			put_le16(ch);
			put_le32(rate);
			put_rand(6);
			put_le16(bits);
			put_rand(size - FMT_BODY_BYTES + size[0]);
		end else begin
			put_rand(size + size[0]);
		end
	endtask

	task automatic build_file(input file_kind_t kind, output int fin_at, output int stop_at);
		logic [31:0] rate;
		logic [31:0] fsize;
		logic [31:0] dsize;
		logic [31:0] big;
		logic [15:0] ch;
		logic [15:0] bits;
		logic [15:0] fmt_tag;
		int          bad_at;
		int          hdr_end;
		int          sent;
		file_q.delete();
		rate = want_rate;
		ch = want_ch;
		bits = want_bits;
		fmt_tag = FMT_PCM;
		fsize = FMT_BODY_BYTES + $urandom_range(0, 5);
		hdr_end = 0;
		bad_at = (kind == FK_BAD_TAG) ? $urandom_range(0, 1) : 2;
		if (kind == FK_MISMATCH) begin
			case ($urandom_range(0, 2))
				0: rate = rate ^ (32'h1 << $urandom_range(0, 31));
				1: ch = ch ^ 16'(32'h1 << $urandom_range(0, 15));
				default: bits = bits ^ 16'(32'h1 << $urandom_range(0, 15));
			endcase
		end
		if (kind == FK_NON_PCM) begin
			fmt_tag = 16'($urandom);
			if (fmt_tag == FMT_PCM) fmt_tag = 16'h0000;
		end
		if (kind == FK_SHORT_FMT) fsize = $urandom_range(0, 15);

		put_tag(bad_at == 0 ? TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)) : TAG_RIFF);
		put_le32($urandom);
		put_tag(bad_at == 1 ? TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)) : TAG_WAVE);

		if (kind == FK_HUGE_CHUNK) begin
			big = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
			if ($urandom_range(0, 1)) begin
				put_tag(TAG_FMT);
				put_le32(big);
				put_le16(FMT_PCM);
			end else begin
				put_other_chunk(big, 0);
			end
			put_rand($urandom_range(0, 24));
			fin_at = file_q.size() - 1;
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				dsize = $urandom_range(0, 7);
				put_other_chunk(dsize, dsize + dsize[0]);
			end
			if (kind == FK_TWO_FMT)
				put_fmt(FMT_BODY_BYTES + $urandom_range(0, 4), FMT_PCM, 16'($urandom), $urandom,
					16'($urandom));
			if (kind != FK_NO_FMT) put_fmt(fsize, fmt_tag, ch, rate, bits);
			if ($urandom_range(0, 3) == 0) begin
				dsize = $urandom_range(0, 7);
				put_other_chunk(dsize, dsize + dsize[0]);
			end
			hdr_end = file_q.size();
			case (kind)
				FK_EMPTY_DATA: dsize = '0;
				FK_END_IN_DATA: dsize = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(2, 24);
				default: dsize = $urandom_range(1, 24);
			endcase
			put_tag(TAG_DATA);
			put_le32(dsize);
			case (kind)
				FK_END_AT_HDR: sent = 0;
				FK_EMPTY_DATA: sent = $urandom_range(0, 3);
				FK_END_IN_DATA: sent = $urandom_range(1, (dsize > 24) ? 24 : dsize - 1);
				FK_CLEAN: sent = dsize + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
				default: sent = dsize;
			endcase
			put_rand(sent);
			fin_at = file_q.size() - 1;
			if (kind == FK_TRUNC_HDR) fin_at = $urandom_range(0, hdr_end + 7);
		end
		// a few bytes after the final mark, without a new first byte
		put_rand(4);
		stop_at = fin_at + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		file_kind_t kind;
		int         fin_at;
		int         stop_at;
		want_rate = RST_RATE;
		want_ch = RST_CHANNELS;
		want_bits = RST_BITS;
		restart_parse();
		foreach (status_hits[i]) status_hits[i] = 0;
		directed_rows = '{
			'{8'h52, 1'b1, 1'b0, '{8'h00, ST_HEADER,   1'b0}},
			'{8'h49, 1'b0, 1'b0, '{8'h00, ST_HEADER,   1'b0}},
			'{8'h46, 1'b0, 1'b0, '{8'h00, ST_HEADER,   1'b0}},
			'{8'h58, 1'b0, 1'b1, '{8'h00, ST_BAD_RIFF, 1'b0}},
			'{8'hFF, 1'b0, 1'b0, '{8'h00, ST_BAD_RIFF, 1'b0}},
			'{8'h00, 1'b1, 1'b1, '{8'h00, ST_TRUNC,    1'b0}},
			'{8'hFF, 1'b0, 1'b0, '{8'h00, ST_TRUNC,    1'b0}},
			'{8'h52, 1'b1, 1'b0, '{8'h00, ST_HEADER,   1'b0}},
			'{8'h49, 1'b0, 1'b0, '{8'h00, ST_HEADER,   1'b0}},
			'{8'h46, 1'b0, 1'b0, '{8'h00, ST_HEADER,   1'b0}},
			'{8'h46, 1'b0, 1'b0, '{8'h00, ST_HEADER,   1'b0}},
			'{8'hFF, 1'b0, 1'b0, '{8'h00, ST_HEADER,   1'b0}},
			'{8'h00, 1'b0, 1'b0, '{8'h00, ST_HEADER,   1'b0}},
			'{8'hFF, 1'b0, 1'b0, '{8'h00, ST_HEADER,   1'b0}},
			'{8'h00, 1'b0, 1'b1, '{8'h00, ST_TRUNC,    1'b0}}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].byte_val, directed_rows[i].is_first,
				  directed_rows[i].is_last, 1'b1, directed_rows[i].res);

		while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
			if (files_sent > 0 && files_sent % FILES_PER_SETTING == 0) begin
				new_setting();
			end else if ($urandom_range(0, 19) == 0) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			if (files_sent < FK_COUNT)
				kind = file_kind_t'(files_sent);
			else if ($urandom_range(0, 1) == 0)
				kind = FK_CLEAN;
			else
				kind = file_kind_t'($urandom_range(1, FK_COUNT - 1));
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			build_file(kind, fin_at, stop_at);
			for (int i = 0; i <= stop_at; i++) begin
				if (kind == FK_NOISE)
					send_byte(file_q[i], $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
						  1'b0, '0);
				else
					send_byte(file_q[i], i == 0, i == fin_at, 1'b0, '0);
			end
			files_sent++;
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d byte transfers in %0d files over %0d register settings",
			 items_sent, files_sent, cfg_rounds + 1);
		$display("Results by status: hdr %0d data %0d past %0d riff %0d fmt %0d mism %0d trunc %0d",
			 status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4],
			 status_hits[5], status_hits[6]);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
